@@ sv/tsrb_pkg.sv @@
// Package for the tilt-shift row blend: widths, fixed-point constants and shared types.
// No dependencies; every other file imports it.
`default_nettype none
package tsrb_pkg;

  // Frame and register geometry
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DS_W     = 7;
  localparam int unsigned FH_W     = 12;
  localparam int unsigned CR_W     = 13;
  localparam int unsigned N_W      = 15;   // signed row offset
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BLUR_SCALE = 2'd0;
  localparam logic [1:0] REG_FOCUS_HALF = 2'd1;
  localparam logic [1:0] REG_CENTER_ROW = 2'd2;

  localparam logic [DS_W-1:0] BLUR_SCALE_RST = 7'd21;
  localparam logic [FH_W-1:0] FOCUS_HALF_RST = 12'd614;
  localparam logic [CR_W-1:0] CENTER_ROW_RST = 13'd2048;

  // Argument divider (Q5.11, saturating at 8.0)
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned ARG_NUM_W = 26;
  localparam int unsigned DIV_STG   = 15;
  localparam int unsigned ARG_SAT   = 16384;

  // Pade tanh in Q1.15
  localparam int unsigned U_W   = 23;
  localparam int unsigned U2_W  = 29;
  localparam int unsigned U3_W  = 35;
  localparam int unsigned P_W   = 38;
  localparam int unsigned Q_W   = 41;
  localparam int unsigned PL_W  = 19;
  localparam int unsigned PP_W  = 34;
  localparam int unsigned XP_W  = 53;
  localparam int unsigned M_W   = 57;
  localparam int unsigned TANH_MAX = 32767;
  localparam logic [Q_W-1:0] PADE_C0 = 41'd8856207360;
  localparam int unsigned PC1 = 17325;
  localparam int unsigned PC2 = 378;
  localparam int unsigned QC1 = 62370;
  localparam int unsigned QC2 = 3150;
  localparam int unsigned QC3 = 28;

  // Blend weights and division by 510 via reciprocal
  localparam logic [15:0] ALPHA_FULL  = 16'd65280;
  localparam int unsigned Y_W         = 17;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_K = 19'd263173;
  localparam logic [7:0] ROUND_ADD = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Signed magnitude with valid, passed from the argument to the tanh units and on to the blend unit
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sgn_t;

  // Channel payload of one pixel
  typedef struct packed {
    logic [2:0][PIX_W-1:0] orig;
    logic [2:0][PIX_W-1:0] blur;
  } pix_t;

endpackage
`default_nettype wire

@@ sv/tilt_shift_row_blend.sv @@
// Top level of the tilt-shift row blend: configuration registers, input stage, channel delay line.
// Depends on tsrb_pkg, tsrb_arg, tsrb_tanh and tsrb_blend.
//
//   channel   | signals                                   | handshake
//   ----------+-------------------------------------------+-------------------------------
//   item in   | row_i, orig_c0..2_i, blur_c0..2_i         | taken when start && !busy
//   result    | out_c0..2_o                               | one cycle, marked by done_o
//   config    | psel, penable, pwrite, paddr, pwdata, ... | APB write in access phase
//
// One item enters every cycle; busy stays low. Each result passes through 1 input stage,
// 16 in the argument divider (a load stage, then one quotient bit per stage), 21 in the
// tanh unit (5 polynomial and product stages plus 16 divider stages) and 4 in the blend
// unit. Reset clears the valid bits and restores the register defaults; data registers
// hold no reset. The pipeline never stalls; the receiver must take every result in the
// cycle it appears, which the block itself does not enforce.
`default_nettype none
module tilt_shift_row_blend (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tsrb_pkg::ROW_W-1:0]    row_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    orig_c0_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    orig_c1_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    orig_c2_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    blur_c0_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    blur_c1_i,
  input  wire logic [tsrb_pkg::PIX_W-1:0]    blur_c2_i,
  output logic                               done_o,
  output logic [tsrb_pkg::PIX_W-1:0]         out_c0_o,
  output logic [tsrb_pkg::PIX_W-1:0]         out_c1_o,
  output logic [tsrb_pkg::PIX_W-1:0]         out_c2_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tsrb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tsrb_pkg::DATA_W-1:0]   pwdata,
  output logic [tsrb_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import tsrb_pkg::*;

  // arg (16) + tanh (21) stages between the input stage and the blend unit
  localparam int unsigned DLY = (DIV_STG + 1) + (DIV_STG + 6);

  logic [DS_W-1:0] blur_scale_q;
  logic [FH_W-1:0] focus_half_q;
  logic [CR_W-1:0] center_row_q;
  logic            wr_en;
  logic [DS_W-1:0] d_eff;

  logic             in_vld_q;
  logic [ROW_W-1:0] row_q;
  pix_t             pix_in_q;
  pix_t             pix_dly_q [0:DLY-1];

  logic [ROW_W-1:0]     row_c;
  logic signed [N_W-1:0] base, n1, n2;

  sgn_t x1, x2, t1, t2;
  logic [2:0][PIX_W-1:0] out_w;

  // ---- configuration port: always ready, decode by word index ----
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_scale_q <= BLUR_SCALE_RST;
      focus_half_q <= FOCUS_HALF_RST;
      center_row_q <= CENTER_ROW_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BLUR_SCALE: blur_scale_q <= pwdata[DS_W-1:0];
        REG_FOCUS_HALF: focus_half_q <= pwdata[FH_W-1:0];
        REG_CENTER_ROW: center_row_q <= pwdata[CR_W-1:0];
        default: ;  // drop writes to unmapped words
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BLUR_SCALE: prdata = DATA_W'(blur_scale_q);
      REG_FOCUS_HALF: prdata = DATA_W'(focus_half_q);
      REG_CENTER_ROW: prdata = DATA_W'(center_row_q);
      default:        prdata = '0;
    endcase
  end

  // a zero divisor acts as one
  assign d_eff = (blur_scale_q == '0) ? DS_W'(1) : blur_scale_q;

  // ---- input stage: the pipeline never stalls, so always take an item ----
  assign busy  = 1'b0;
  assign row_c = (32'(row_i) >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) : row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q         <= row_c;
    pix_in_q.orig <= {orig_c2_i, orig_c1_i, orig_c0_i};
    pix_in_q.blur <= {blur_c2_i, blur_c1_i, blur_c0_i};
  end

  // signed offsets of the two band edges
  always_comb begin
    base = $signed(N_W'(row_q)) - $signed(N_W'(center_row_q));
    n1   = base + $signed(N_W'(focus_half_q));
    n2   = base - $signed(N_W'(focus_half_q));
  end

  // ---- channels ride a delay line matched to the weight path ----
  always_ff @(posedge clk_i) begin
    pix_dly_q[0] <= pix_in_q;
    for (int k = 1; k < DLY; k++) begin
      pix_dly_q[k] <= pix_dly_q[k-1];
    end
  end

  // ---- weight path: both band edges in parallel ----
  tsrb_arg u_arg1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .n_i     (n1),
    .d_i     (d_eff),
    .x_o     (x1)
  );

  tsrb_arg u_arg2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .n_i     (n2),
    .d_i     (d_eff),
    .x_o     (x2)
  );

  tsrb_tanh u_tanh1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (x1),
    .t_o    (t1)
  );

  // u_tanh2's valid bit mirrors that of u_tanh1
  tsrb_tanh u_tanh2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (x2),
    .t_o    (t2)
  );

  tsrb_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .t1_i   (t1),
    .t2_i   (t2),
    .pix_i  (pix_dly_q[DLY-1]),
    .done_o (done_o),
    .out_o  (out_w)
  );

  assign out_c0_o = out_w[0];
  assign out_c1_o = out_w[1];
  assign out_c2_o = out_w[2];

endmodule
`default_nettype wire

@@ sv/tsrb_arg.sv @@
// Argument unit: |n|*2048/d rounded and saturated, as a pipelined restoring divider.
// Depends on tsrb_pkg.
`default_nettype none
module tsrb_arg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic signed [tsrb_pkg::N_W-1:0] n_i,
  input  wire logic [tsrb_pkg::DS_W-1:0]    d_i,
  output tsrb_pkg::sgn_t                    x_o
);
  import tsrb_pkg::*;

  logic [DIV_STG:0]     vld_q;
  logic                 neg_q [0:DIV_STG];
  logic                 sat_q [0:DIV_STG];
  logic [ARG_NUM_W-1:0] rem_q [0:DIV_STG];
  logic [MAG_W-1:0]     quo_q [0:DIV_STG];

  logic [MAG_W-1:0]     mag;
  logic [ARG_NUM_W-1:0] num;
  logic                 sat;

  always_comb begin
    mag = n_i[N_W-1] ? MAG_W'(-n_i) : MAG_W'(n_i);
    num = (ARG_NUM_W'(mag) << 11) + ARG_NUM_W'(d_i >> 1);
    sat = num >= (ARG_NUM_W'(d_i) * ARG_NUM_W'(ARG_SAT + 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STG-1:0], valid_i};
    end
  end

  // one quotient bit per stage, most significant first
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num;
    quo_q[0] <= '0;
    neg_q[0] <= n_i[N_W-1];
    sat_q[0] <= sat;
    for (int k = 1; k <= DIV_STG; k++) begin
      neg_q[k] <= neg_q[k-1];
      sat_q[k] <= sat_q[k-1];
      if (rem_q[k-1] >= (ARG_NUM_W'(d_i) << (DIV_STG - k))) begin
        rem_q[k] <= rem_q[k-1] - (ARG_NUM_W'(d_i) << (DIV_STG - k));
        quo_q[k] <= quo_q[k-1] | (MAG_W'(1) << (DIV_STG - k));
      end else begin
        rem_q[k] <= rem_q[k-1];
        quo_q[k] <= quo_q[k-1];
      end
    end
  end

  assign x_o.valid = vld_q[DIV_STG];
  assign x_o.neg   = neg_q[DIV_STG];
  assign x_o.mag   = sat_q[DIV_STG] ? MAG_W'(ARG_SAT) : quo_q[DIV_STG];

endmodule
`default_nettype wire

@@ sv/tsrb_tanh.sv @@
// Tanh unit: Pade polynomials, split product and pipelined divider, Q5.11 in, Q1.15 out.
// Depends on tsrb_pkg.
`default_nettype none
module tsrb_tanh (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  tsrb_pkg::sgn_t x_i,
  output tsrb_pkg::sgn_t t_o
);
  import tsrb_pkg::*;

  localparam int unsigned PRE = 6;
  localparam int unsigned LAT = PRE + DIV_STG;

  logic [LAT-1:0]   vld_q;
  logic             neg_q [0:LAT-1];
  logic [MAG_W-1:0] x_q   [0:3];

  logic [U_W-1:0]   u_q  [1:3];
  logic [U2_W-1:0]  u2_q [2:3];
  logic [U3_W-1:0]  u3_q;
  logic [P_W-1:0]   p_q;
  logic [Q_W-1:0]   q4_q;
  logic [PP_W-1:0]  ph_q, pl_q;
  logic [Q_W-1:0]   q5_q;

  logic [M_W-1:0]   rem_q [0:DIV_STG];
  logic [Q_W-1:0]   den_q [0:DIV_STG];
  logic [MAG_W-1:0] quo_q [0:DIV_STG];
  logic             sat_q [0:DIV_STG];

  logic [2*MAG_W-1:0] xx;
  logic [2*U_W-1:0]   uu;
  logic [U2_W+U_W-1:0] uu2;
  logic [XP_W-1:0]    xp;
  logic [M_W-1:0]     m;

  always_comb begin
    xx  = (2*MAG_W)'(x_i.mag) * (2*MAG_W)'(x_i.mag);
    uu  = (2*U_W)'(u_q[1]) * (2*U_W)'(u_q[1]);
    uu2 = (U2_W+U_W)'(u2_q[2]) * (U2_W+U_W)'(u_q[2]);
    xp  = (XP_W'(ph_q) << PL_W) + XP_W'(pl_q);
    m   = (M_W'(xp) << 4) + M_W'(q5_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], x_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= x_i.neg;
    for (int k = 1; k < LAT; k++) begin
      neg_q[k] <= neg_q[k-1];
    end
    // square, then powers of x^2
    x_q[0]  <= x_i.mag;
    u_q[1]  <= U_W'(xx >> 6);
    x_q[1]  <= x_q[0];
    u_q[2]  <= u_q[1];
    u2_q[2] <= U2_W'(uu >> 16);
    x_q[2]  <= x_q[1];
    u_q[3]  <= u_q[2];
    u2_q[3] <= u2_q[2];
    u3_q    <= U3_W'(uu2 >> 16);
    // numerator and denominator polynomials
    x_q[3]  <= x_q[2];
    p_q     <= P_W'(PADE_C0) + P_W'(u_q[3]) * P_W'(PC1) + P_W'(u2_q[3]) * P_W'(PC2)
             + P_W'(u3_q);
    q4_q    <= PADE_C0 + Q_W'(u_q[3]) * Q_W'(QC1) + Q_W'(u2_q[3]) * Q_W'(QC2)
             + Q_W'(u3_q) * Q_W'(QC3);
    // x*P in two partial products
    ph_q    <= PP_W'(x_q[3]) * PP_W'(p_q[P_W-1:PL_W]);
    pl_q    <= PP_W'(x_q[3]) * PP_W'(p_q[PL_W-1:0]);
    q5_q    <= q4_q;
    // rounded numerator and saturation test
    rem_q[0] <= m;
    den_q[0] <= q5_q;
    quo_q[0] <= '0;
    sat_q[0] <= m >= (M_W'(q5_q) << MAG_W);
    for (int k = 1; k <= DIV_STG; k++) begin
      den_q[k] <= den_q[k-1];
      sat_q[k] <= sat_q[k-1];
      if (rem_q[k-1] >= (M_W'(den_q[k-1]) << (DIV_STG - k))) begin
        rem_q[k] <= rem_q[k-1] - (M_W'(den_q[k-1]) << (DIV_STG - k));
        quo_q[k] <= quo_q[k-1] | (MAG_W'(1) << (DIV_STG - k));
      end else begin
        rem_q[k] <= rem_q[k-1];
        quo_q[k] <= quo_q[k-1];
      end
    end
  end

  assign t_o.valid = vld_q[LAT-1];
  assign t_o.neg   = neg_q[LAT-1];
  assign t_o.mag   = sat_q[DIV_STG] ? MAG_W'(TANH_MAX) : quo_q[DIV_STG];

endmodule
`default_nettype wire

@@ sv/tsrb_blend.sv @@
// Blend unit: weights from the two tanh values, scaled channel sums, saturation.
// Depends on tsrb_pkg.
`default_nettype none
module tsrb_blend (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  tsrb_pkg::sgn_t                 t1_i,
  input  tsrb_pkg::sgn_t                 t2_i,
  input  tsrb_pkg::pix_t                 pix_i,
  output logic                           done_o,
  output logic [2:0][tsrb_pkg::PIX_W-1:0] out_o
);
  import tsrb_pkg::*;

  logic [3:0]                    vld_q;
  logic [PIX_W-1:0]              wa_q, wb_q;
  pix_t                          pix_q;
  logic [2:0][Y_W-1:0]           ya_q, yb_q;
  logic [2:0][Y_W+RECIP_W-1:0]   pa_q, pb_q;
  logic [2:0][PIX_W-1:0]         out_q;

  logic signed [MAG_W+1:0] t1s, t2s, diff;
  logic [15:0]             dpos;
  logic [23:0]             alpha_w;
  logic [15:0]             alpha;
  logic [2:0][PIX_W:0]     sum;

  always_comb begin
    t1s   = t1_i.neg ? -$signed((MAG_W+2)'(t1_i.mag)) : $signed((MAG_W+2)'(t1_i.mag));
    t2s   = t2_i.neg ? -$signed((MAG_W+2)'(t2_i.mag)) : $signed((MAG_W+2)'(t2_i.mag));
    diff  = t1s - t2s;
    dpos  = diff[MAG_W+1] ? '0 : diff[15:0];
    alpha_w = 24'(dpos) * 24'(PIX_MAX);
    alpha = alpha_w[23:8];
    for (int k = 0; k < 3; k++) begin
      sum[k] = (PIX_W+1)'(pa_q[k][RECIP_SHIFT +: PIX_W])
             + (PIX_W+1)'(pb_q[k][RECIP_SHIFT +: PIX_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], t1_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= alpha[15:8];
    wb_q  <= 8'((ALPHA_FULL - alpha) >> 8);
    pix_q <= pix_i;
    for (int k = 0; k < 3; k++) begin
      // 2*v*w + 255, later divided by 510 through a reciprocal
      ya_q[k] <= ((Y_W'(pix_q.orig[k]) * Y_W'(wa_q)) << 1) + Y_W'(ROUND_ADD);
      yb_q[k] <= ((Y_W'(pix_q.blur[k]) * Y_W'(wb_q)) << 1) + Y_W'(ROUND_ADD);
      pa_q[k] <= (Y_W+RECIP_W)'(ya_q[k]) * (Y_W+RECIP_W)'(RECIP_K);
      pb_q[k] <= (Y_W+RECIP_W)'(yb_q[k]) * (Y_W+RECIP_W)'(RECIP_K);
      out_q[k] <= sum[k][PIX_W] ? PIX_MAX : sum[k][PIX_W-1:0];
    end
  end

  assign done_o = vld_q[3];
  assign out_o  = out_q;

endmodule
`default_nettype wire
